// File: hw/rtl/adl_pkg.sv
package adl_pkg;

   localparam int LANE_COUNT         = 4;
   localparam int NUM_INPUT_FEATURES = 4;

   localparam int FEAT_W     = 16;
   localparam int WEIGHT_W   = 32;
   localparam int LR_W       = 16;
   localparam int LABEL_W    = 2;
   localparam int CLASS_W    = 2;
   localparam int CORR_W     = 18;
   localparam int FRAC_SHIFT = 8;

   localparam int PROD_W      = FEAT_W + WEIGHT_W;
   localparam int SUM_W       = PROD_W + $clog2(LANE_COUNT + 1);
   localparam int SHIFTED_W   = SUM_W - FRAC_SHIFT;
   localparam int DELTA_W     = CORR_W + FEAT_W;

   localparam logic [LR_W-1:0] LR_RESET = LR_W'(655);

   typedef logic signed [FEAT_W-1:0]   feat_type;
   typedef logic signed [WEIGHT_W-1:0] weight_type;
   typedef logic signed [PROD_W-1:0]   prod_type;
   typedef logic signed [SUM_W-1:0]    sum_type;
   typedef logic signed [SHIFTED_W-1:0] wide_type;
   typedef logic signed [DELTA_W-1:0]  delta_type;
   typedef logic signed [CORR_W-1:0]   corr_type;
   typedef logic signed [CLASS_W-1:0]  class_type;
   typedef logic signed [LABEL_W-1:0]  label_type;

   localparam weight_type ONE_Q16    = weight_type'(65536);
   localparam weight_type WEIGHT_MAX = {1'b0, {(WEIGHT_W-1){1'b1}}};
   localparam weight_type WEIGHT_MIN = {1'b1, {(WEIGHT_W-1){1'b0}}};

   localparam class_type CLASS_POS = class_type'(1);
   localparam class_type CLASS_NEG = class_type'(-1);
   localparam label_type LABEL_NEG2 = label_type'(-2);
   localparam label_type LABEL_NEG1 = label_type'(-1);

   typedef struct packed {
      logic load_feat;
      logic load_prod;
      logic load_delta;
      logic update;
   } lane_ctrl_type;

   // Clamp a wide signed value to the signed 32-bit weight range.
   function automatic weight_type sat_weight(input wide_type v);
      wide_type hi;
      wide_type lo;
      hi = {{(SHIFTED_W-WEIGHT_W){1'b0}}, WEIGHT_MAX};
      lo = {{(SHIFTED_W-WEIGHT_W){1'b1}}, WEIGHT_MIN};
      if (v > hi) begin
         return WEIGHT_MAX;
      end else if (v < lo) begin
         return WEIGHT_MIN;
      end
      return v[WEIGHT_W-1:0];
   endfunction

endpackage

// File: hw/rtl/adl_if.sv
interface adl_req_if;
   logic                 valid;
   logic                 ready;
   logic                 cmd;
   adl_pkg::label_type   label;
   adl_pkg::feat_type    feature_0;
   adl_pkg::feat_type    feature_1;
   adl_pkg::feat_type    feature_2;
   adl_pkg::feat_type    feature_3;

   modport source (output valid, cmd, label, feature_0, feature_1, feature_2, feature_3,
                   input ready);
   modport sink (input valid, cmd, label, feature_0, feature_1, feature_2, feature_3,
                 output ready);
endinterface

interface adl_rsp_if;
   logic                 valid;
   logic                 ready;
   adl_pkg::class_type   predicted_class;
   adl_pkg::weight_type  net_sum;
   adl_pkg::corr_type    correction;

   modport source (output valid, predicted_class, net_sum, correction, input ready);
   modport sink (input valid, predicted_class, net_sum, correction, output ready);
endinterface

interface adl_csr_if;
   logic                       valid;
   logic                       ready;
   logic [adl_pkg::LR_W-1:0]   data;

   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

// File: hw/rtl/adl_lane.sv
module adl_lane (
   input  logic                   clock,
   input  logic                   reset,
   input  adl_pkg::lane_ctrl_type ctrl,
   input  adl_pkg::feat_type      feature,
   input  adl_pkg::corr_type      corr,
   output adl_pkg::prod_type      prod
);

   adl_pkg::feat_type   feat_ff;
   adl_pkg::weight_type weight_ff;
   adl_pkg::weight_type weight_in;
   adl_pkg::prod_type   prod_ff;
   adl_pkg::prod_type   prod_in;
   adl_pkg::delta_type  delta_ff;
   adl_pkg::delta_type  delta_in;
   adl_pkg::wide_type   weight_sum;

   always_comb begin
      prod_in  = adl_pkg::prod_type'(feat_ff) * adl_pkg::prod_type'(weight_ff);
      delta_in = adl_pkg::delta_type'(corr) * adl_pkg::delta_type'(feat_ff);
      // Arithmetic shift rounds the Q10.24 step toward minus infinity.
      weight_sum = adl_pkg::wide_type'(weight_ff)
                 + adl_pkg::wide_type'(delta_ff >>> adl_pkg::FRAC_SHIFT);
      weight_in  = adl_pkg::sat_weight(weight_sum);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         weight_ff <= adl_pkg::ONE_Q16;
      end else if (ctrl.update) begin
         weight_ff <= weight_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load_feat) begin
         feat_ff <= feature;
      end
      if (ctrl.load_prod) begin
         prod_ff <= prod_in;
      end
      if (ctrl.load_delta) begin
         delta_ff <= delta_in;
      end
   end

   assign prod = prod_ff;

endmodule

// File: hw/rtl/adl_merge.sv
module adl_merge (
   input  logic                clock,
   input  logic                load,
   input  adl_pkg::prod_type   prod [adl_pkg::LANE_COUNT],
   input  adl_pkg::weight_type bias,
   output adl_pkg::weight_type net_sum,
   output adl_pkg::class_type  pred_class
);

   adl_pkg::sum_type  sum_ff;
   adl_pkg::sum_type  sum_in;
   adl_pkg::wide_type shifted;

   always_comb begin
      sum_in = adl_pkg::sum_type'(bias) <<< adl_pkg::FRAC_SHIFT;
      for (int i = 0; i < adl_pkg::LANE_COUNT; i++) begin
         sum_in = sum_in + adl_pkg::sum_type'(prod[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         sum_ff <= sum_in;
      end
   end

   // Back to Q16.16, rounding toward minus infinity, then clamp.
   assign shifted    = adl_pkg::wide_type'(sum_ff >>> adl_pkg::FRAC_SHIFT);
   assign net_sum    = adl_pkg::sat_weight(shifted);
   assign pred_class = (net_sum > 0) ? adl_pkg::CLASS_POS : adl_pkg::CLASS_NEG;

endmodule

// File: hw/rtl/adaline_neuron_train_predict_core.sv
// Single-layer linear neuron (ADALINE) with on-line training. A request beat carries four
// Q8.8 features and a command: predict returns the Q16.16 net sum, saturated, and its sign
// class; fit returns the same and then moves each weight by eta times (label minus class)
// times its feature, and the bias by eta times (label minus class). The four feature lanes
// multiply in parallel and a merge stage adds the products to the bias. One item is in
// flight at a time: a predict passes the multiply, sum and classify steps before the next
// request can be accepted, a fit also the two-step weight update (multiply, then add and
// saturate). The response is registered at the classify step and waits in an output
// register; the next request is accepted while it waits. If the previous response is still
// waiting when the classify step is reached, the item holds there until that response is
// taken, which delays this response and the next acceptance. The learning rate register
// resets to 655 and is written through the csr channel, which is always ready.
module adaline_neuron_train_predict_core (
   input  logic         clock,
   input  logic         reset,
   adl_req_if.sink      req,
   adl_rsp_if.source    rsp,
   adl_csr_if.sink      csr
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_MUL  = 3'd1;
   localparam logic [2:0] ST_SUM  = 3'd2;
   localparam logic [2:0] ST_CLS  = 3'd3;
   localparam logic [2:0] ST_DMUL = 3'd4;
   localparam logic [2:0] ST_UPD  = 3'd5;

   logic [2:0]                 state_ff;
   logic [2:0]                 state_in;
   logic [adl_pkg::LR_W-1:0]   lr_ff;
   logic                       cmd_ff;
   adl_pkg::label_type         label_ff;
   adl_pkg::weight_type        bias_ff;
   adl_pkg::weight_type        bias_in;
   adl_pkg::corr_type          corr_ff;
   adl_pkg::corr_type          corr_in;
   adl_pkg::label_type         label_eff;
   adl_pkg::corr_type          lr_s;
   adl_pkg::corr_type          diff_s;
   logic                       rsp_valid_ff;
   adl_pkg::class_type         rsp_class_ff;
   adl_pkg::weight_type        rsp_net_ff;
   adl_pkg::corr_type          rsp_corr_ff;
   logic                       accept;
   logic                       out_free;
   logic                       cls_done;
   adl_pkg::lane_ctrl_type     lane_ctrl;
   adl_pkg::feat_type          req_feat [adl_pkg::NUM_INPUT_FEATURES];
   adl_pkg::feat_type          lane_feat [adl_pkg::LANE_COUNT];
   adl_pkg::prod_type          lane_prod [adl_pkg::LANE_COUNT];
   adl_pkg::weight_type        net_sum;
   adl_pkg::class_type         pred_class;

   assign req.ready = (state_ff == ST_IDLE);
   assign accept    = req.valid && req.ready;
   assign csr.ready = 1'b1;
   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign cls_done  = (state_ff == ST_CLS) && out_free;

   assign req_feat[0] = req.feature_0;
   assign req_feat[1] = req.feature_1;
   assign req_feat[2] = req.feature_2;
   assign req_feat[3] = req.feature_3;

   always_comb begin
      lane_ctrl.load_feat  = accept;
      lane_ctrl.load_prod  = (state_ff == ST_MUL);
      lane_ctrl.load_delta = (state_ff == ST_DMUL);
      lane_ctrl.update     = (state_ff == ST_UPD);
   end

   for (genvar i = 0; i < adl_pkg::LANE_COUNT; i++) begin : g_lane
      if (i < adl_pkg::NUM_INPUT_FEATURES) begin : g_fed
         assign lane_feat[i] = req_feat[i];
      end else begin : g_zero
         assign lane_feat[i] = '0;
      end

      adl_lane u_lane (
         .clock   (clock),
         .reset   (reset),
         .ctrl    (lane_ctrl),
         .feature (lane_feat[i]),
         .corr    (corr_ff),
         .prod    (lane_prod[i])
      );
   end

   adl_merge u_merge (
      .clock      (clock),
      .load       (state_ff == ST_SUM),
      .prod       (lane_prod),
      .bias       (bias_ff),
      .net_sum    (net_sum),
      .pred_class (pred_class)
   );

   // A label of -2 counts as -1; the difference with the class then stays within +-2.
   always_comb begin
      label_eff = (label_ff == adl_pkg::LABEL_NEG2) ? adl_pkg::LABEL_NEG1 : label_ff;
      lr_s      = adl_pkg::corr_type'({1'b0, lr_ff});
      diff_s    = adl_pkg::corr_type'(label_eff) - adl_pkg::corr_type'(pred_class);
      corr_in   = cmd_ff ? adl_pkg::corr_type'(lr_s * diff_s) : '0;
      bias_in   = adl_pkg::sat_weight(adl_pkg::wide_type'(bias_ff)
                                    + adl_pkg::wide_type'(corr_ff));
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL:  state_in = ST_SUM;
         ST_SUM:  state_in = ST_CLS;
         ST_CLS: begin
            if (out_free) begin
               state_in = cmd_ff ? ST_DMUL : ST_IDLE;
            end
         end
         ST_DMUL: state_in = ST_UPD;
         ST_UPD:  state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         lr_ff        <= adl_pkg::LR_RESET;
         bias_ff      <= adl_pkg::ONE_Q16;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr.valid) begin
            lr_ff <= csr.data;
         end
         if (state_ff == ST_UPD) begin
            bias_ff <= bias_in;
         end
         if (cls_done) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff   <= req.cmd;
         label_ff <= req.label;
      end
      if (cls_done) begin
         corr_ff      <= corr_in;
         rsp_class_ff <= pred_class;
         rsp_net_ff   <= net_sum;
         rsp_corr_ff  <= corr_in;
      end
   end

   assign rsp.valid           = rsp_valid_ff;
   assign rsp.predicted_class = rsp_class_ff;
   assign rsp.net_sum         = rsp_net_ff;
   assign rsp.correction      = rsp_corr_ff;

   // A weight update always ends the item.
   a_upd_to_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UPD) |=> (state_ff == ST_IDLE))
      else $error("update step not followed by idle");

   // A predict never touches the weights.
   a_predict_no_update: assert property (@(posedge clock) disable iff (reset)
      (cls_done && !cmd_ff) |=> (state_ff == ST_IDLE) && $stable(bias_ff))
      else $error("predict item entered the update steps");

   // A response only comes out of the classify step.
   a_rsp_from_cls: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_CLS))
      else $error("response raised outside the classify step");

   // No response is produced before the previous one is taken.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp.ready) |=> rsp_valid_ff && $stable(rsp_net_ff))
      else $error("pending response overwritten");

endmodule
